FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is held.
`define LRR_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lcg_ranged_random: property violated");

// Condition that must never hold at a clock edge.
`define LRR_ASSERT_NEVER(name, clk, rst_n, cond) \
  `LRR_ASSERT(name, clk, rst_n, !(cond))

`endif

FILE: rtl/lrr_pkg.sv
`timescale 1ns / 1ps
package lrr_pkg;

  // Command carried in tuser of the input beat.
  localparam logic CMD_RESEED = 1'b0;
  localparam logic CMD_DRAW   = 1'b1;

  // Generator step: seed = seed * LCG_MUL + LCG_ADD (mod 2^32).
  localparam logic [31:0] LCG_MUL = 32'd214013;
  localparam logic [31:0] LCG_ADD = 32'd2531011;

  // Raw draw is seed bits [RAW_LSB + RAW_W - 1 : RAW_LSB].
  localparam int RAW_W   = 15;
  localparam int RAW_LSB = 16;

  // Status of the serial remainder unit.
  typedef struct packed {
    logic busy;
    logic done;
  } lrr_div_stat_t;

endpackage

FILE: rtl/lrr_divider.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Restoring remainder, one dividend bit per cycle.
module lrr_divider
  import lrr_pkg::*;
#(
  parameter int DW = 15
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [RAW_W-1:0]     dividend,
  input  logic [DW-1:0]        divisor,
  output lrr_div_stat_t        stat,
  output logic [DW-1:0]        remainder
);

  localparam int CNT_W = $clog2(RAW_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0]    rem_r;
  logic [RAW_W-1:0] dvd_r;
  logic [DW-1:0]    dsr_r;

  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic [DW-1:0]    rem_nxt;

  always_comb begin
    trial   = {rem_r, dvd_r[RAW_W-1]};
    diff    = trial - {1'b0, dsr_r};
    // keep the difference when the divisor fits, else the shifted partial
    rem_nxt = (trial >= {1'b0, dsr_r}) ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // flag done for one cycle after the last bit
      done_r <= !start && busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(RAW_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[RAW_W-2:0], 1'b0};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign remainder = rem_r;

  `LRR_ASSERT(a_rem_below_divisor, clk, rst_n, (busy_r || done_r) |-> (rem_r < dsr_r))
  `LRR_ASSERT(a_done_after_busy, clk, rst_n, done_r |-> $past(busy_r))
  `LRR_ASSERT_NEVER(a_no_restart, clk, rst_n, start && busy_r)

endmodule

FILE: rtl/lcg_ranged_random.sv
// Path: reseed S_IDLE, S_OUT; refused draw S_IDLE, S_CHECK, S_OUT; draw S_IDLE, S_CHECK,
//   S_ADV, S_DIV, S_OUT, then the output register. Throughput: one item at a time.
// The draw time is set by the serial remainder unit, which retires one raw bit per cycle.
// The next input beat is taken while a result beat still waits in the output register.
// Reset (rst_n low, synchronous) clears the sequencer, the output valid and the seed to 0.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lcg_ranged_random
  import lrr_pkg::*;
#(
  parameter int unsigned RANGE_LIMIT = 32767
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // [31:0] new_seed, [63:32] range_low, [95:64] range_high
  input  logic        in_tuser,   // [0] command
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value
  output logic [1:0]  out_tuser   // [0] range_error, [1] bounds_swapped
);

  // Divisor is span + 1, which never exceeds RANGE_LIMIT.
  localparam int DIV_W = $clog2(RANGE_LIMIT + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ADV,
    S_DIV,
    S_OUT
  } state_t;

  state_t             state_r, state_nxt;
  logic [31:0]        seed_r, seed_nxt;
  logic signed [31:0] lo_r, lo_nxt;
  logic signed [31:0] hi_r, hi_nxt;
  logic               swapped_r, swapped_nxt;
  logic [DIV_W-1:0]   divisor_r, divisor_nxt;
  logic [31:0]        res_value_r, res_value_nxt;
  logic               res_err_r, res_err_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [31:0]        out_value_r, out_value_nxt;
  logic               out_err_r, out_err_nxt;
  logic               out_swp_r, out_swp_nxt;

  logic               in_acc;
  logic signed [31:0] in_lo;
  logic signed [31:0] in_hi;
  logic [32:0]        span;
  logic [31:0]        seed_step;
  logic               div_start;
  lrr_div_stat_t      div_stat;
  logic [DIV_W-1:0]   div_rem;

  assign in_acc = in_tvalid && in_tready;
  assign in_lo  = $signed(in_tdata[63:32]);
  assign in_hi  = $signed(in_tdata[95:64]);

  // Span of ordered bounds is non-negative and needs 33 bits.
  assign span = {hi_r[31], hi_r} - {lo_r[31], lo_r};

  // Advance the generator: one 32 x 18 multiply, truncated to 32 bits.
  assign seed_step = seed_r * LCG_MUL + LCG_ADD;

  assign div_start = (state_r == S_ADV);

  lrr_divider #(
    .DW(DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (seed_step[RAW_LSB +: RAW_W]),
    .divisor  (divisor_r),
    .stat     (div_stat),
    .remainder(div_rem)
  );

  always_comb begin
    state_nxt      = state_r;
    seed_nxt       = seed_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    swapped_nxt    = swapped_r;
    divisor_nxt    = divisor_r;
    res_value_nxt  = res_value_r;
    res_err_nxt    = res_err_r;
    out_tvalid_nxt = out_tvalid_r;
    out_value_nxt  = out_value_r;
    out_err_nxt    = out_err_r;
    out_swp_nxt    = out_swp_r;

    // drop the result beat once it is taken
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == CMD_RESEED) begin
            seed_nxt      = in_tdata[31:0];
            swapped_nxt   = 1'b0;
            res_value_nxt = '0;
            res_err_nxt   = 1'b0;
            state_nxt     = S_OUT;
          end else begin
            // order the bounds and flag a reversed pair
            swapped_nxt = (in_hi < in_lo);
            lo_nxt      = (in_hi < in_lo) ? in_hi : in_lo;
            hi_nxt      = (in_hi < in_lo) ? in_lo : in_hi;
            state_nxt   = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (span >= 33'(RANGE_LIMIT)) begin
          // refuse the draw, hold the seed
          res_value_nxt = '0;
          res_err_nxt   = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          divisor_nxt = span[DIV_W-1:0] + DIV_W'(1);
          res_err_nxt = 1'b0;
          state_nxt   = S_ADV;
        end
      end
      S_ADV: begin
        seed_nxt  = seed_step;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          res_value_nxt = lo_r + 32'(div_rem);
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        // load the output register as soon as it is free
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_value_nxt  = res_value_r;
          out_err_nxt    = res_err_r;
          out_swp_nxt    = swapped_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      seed_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      seed_r       <= seed_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    swapped_r   <= swapped_nxt;
    divisor_r   <= divisor_nxt;
    res_value_r <= res_value_nxt;
    res_err_r   <= res_err_nxt;
    out_value_r <= out_value_nxt;
    out_err_r   <= out_err_nxt;
    out_swp_r   <= out_swp_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = {out_swp_r, out_err_r};

  `LRR_ASSERT(a_err_value_zero, clk, rst_n, (out_tvalid_r && out_err_r) |-> (out_value_r == 32'd0))
  `LRR_ASSERT(a_seed_hold, clk, rst_n, ((state_r != S_ADV) && !(in_acc && (in_tuser == CMD_RESEED))) |=> $stable(seed_r))
  `LRR_ASSERT_NEVER(a_idle_div_busy, clk, rst_n, (state_r == S_IDLE) && div_stat.busy)

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lrr_pkg::*;

  localparam int RANGE_LIMIT = 32767;
  localparam int QUIET_LIMIT = 3000;   // cycles with no beat on either side
  localparam int LONG_STALL  = 400;    // receiver hold-off, in cycles
  localparam int SETTLE      = 50;     // tail after the last result
  localparam longint INT_MAX = 64'sd2147483647;
  localparam longint INT_MIN = -64'sd2147483648;

  // One request as the sender presents it on the input channel.
  typedef struct {
    logic        cmd;
    logic [31:0] seed;
    logic [31:0] lo;
    logic [31:0] hi;
  } request_t;

  // One result beat, fields as they travel on out_tdata / out_tuser.
  typedef struct packed {
    logic [31:0] value;
    logic        range_error;
    logic        bounds_swapped;
  } draw_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;   // [31:0] new_seed, [63:32] range_low, [95:64] range_high
  logic        in_tuser;   // [0] command
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] value
  logic [1:0]  out_tuser;  // [0] range_error, [1] bounds_swapped

  request_t     request_q[$];       // requests not yet accepted by the block
  draw_result_t draw_results_q[$];  // predicted results, oldest first
  logic [31:0]  gen_seed;           // shadow of the generator seed
  draw_result_t want;

  logic        in_fire;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned result_count;
  int unsigned long_stall_left;
  logic        long_stall_done;
  int unsigned rx_mode;
  int unsigned rx_phase_left;
  int unsigned quiet_cycles;
  int unsigned fail_count;

  lcg_ranged_random #(
    .RANGE_LIMIT(RANGE_LIMIT)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Predict the result of one accepted beat and advance the shadow seed.
  // Bounds are widened to 64 bits so the span never wraps.
  function automatic draw_result_t next_draw(logic cmd, logic [31:0] new_seed,
                                             logic signed [31:0] lo_in,
                                             logic signed [31:0] hi_in);
    draw_result_t r;
    longint lo;
    longint hi;
    longint span;
    longint raw;
    r  = '0;
    lo = lo_in;
    hi = hi_in;
    if (cmd == CMD_RESEED) begin
      gen_seed = new_seed;
      return r;
    end
    if (hi < lo) begin
      lo = hi_in;
      hi = lo_in;
      r.bounds_swapped = 1'b1;
    end
    span = hi - lo;
    // Refused draw: seed stays where it is.
    if (span >= RANGE_LIMIT) begin
      r.range_error = 1'b1;
      return r;
    end
    gen_seed = gen_seed * LCG_MUL + LCG_ADD;
    raw      = gen_seed[RAW_LSB +: RAW_W];
    r.value  = 32'(lo + raw % (span + 1));
    return r;
  endfunction

  task automatic add_request(logic cmd, logic [31:0] seed, logic [31:0] lo, logic [31:0] hi);
    request_t q;
    q.cmd  = cmd;
    q.seed = seed;
    q.lo   = lo;
    q.hi   = hi;
    request_q.push_back(q);
  endtask

  // Draw with a given span at a random position; optionally give the bounds reversed.
  task automatic add_span_draw(longint span, bit reverse);
    int     r;
    longint lo;
    longint hi;
    r  = $urandom;
    lo = r;
    if (lo + span > INT_MAX) lo = INT_MAX - span;
    hi = lo + span;
    if (reverse) add_request(CMD_DRAW, $urandom, 32'(hi), 32'(lo));
    else         add_request(CMD_DRAW, $urandom, 32'(lo), 32'(hi));
  endtask

  // Random mix: mostly in-range draws with small or wide spans, some spans
  // straddling the limit, some fully random bounds, some equal bounds, reseeds now and then.
  task automatic add_random(int unsigned count);
    int unsigned pick;
    int          lo_r;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        case ($urandom_range(0, 5))
          0:       add_request(CMD_RESEED, 32'h0000_0000, $urandom, $urandom);
          1:       add_request(CMD_RESEED, 32'hFFFF_FFFF, $urandom, $urandom);
          default: add_request(CMD_RESEED, $urandom, $urandom, $urandom);
        endcase
      end else if (pick < 35) begin
        add_span_draw($urandom_range(0, 255), $urandom_range(0, 2) == 0);
      end else if (pick < 55) begin
        add_span_draw($urandom_range(0, RANGE_LIMIT - 1), $urandom_range(0, 2) == 0);
      end else if (pick < 70) begin
        add_span_draw($urandom_range(RANGE_LIMIT - 8, RANGE_LIMIT + 8),
                      $urandom_range(0, 2) == 0);
      end else if (pick < 88) begin
        add_request(CMD_DRAW, $urandom, $urandom, $urandom);
      end else begin
        lo_r = $urandom;
        add_request(CMD_DRAW, $urandom, lo_r, lo_r);
      end
    end
  endtask

  // Block until every request is taken and every predicted result is seen.
  task automatic wait_drained();
    while (request_q.size() != 0 || draw_results_q.size() != 0 || in_tvalid)
      @(posedge clk);
  endtask

  // Driver: present the head of the request queue in bursts with gaps between.
  always @(negedge clk) begin
    if (in_fire) request_q.delete(0);
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_fire) begin
      // hold the beat until the block takes it
    end else if (request_q.size() == 0 || gap_left != 0) begin
      in_tvalid <= 1'b0;
      if (gap_left != 0) gap_left <= gap_left - 1;
    end else begin
      in_tvalid <= 1'b1;
      in_tuser  <= request_q[0].cmd;
      in_tdata  <= {request_q[0].hi, request_q[0].lo, request_q[0].seed};
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // Receiver: change stall behavior in phases; once, hold off long enough
  // for the block to back up and drop in_tready.
  always @(negedge clk) begin
    if (long_stall_left != 0) begin
      long_stall_left <= long_stall_left - 1;
      out_tready      <= 1'b0;
    end else if (!long_stall_done && result_count >= 150) begin
      long_stall_left <= LONG_STALL;
      long_stall_done <= 1'b1;
      out_tready      <= 1'b0;
    end else begin
      if (rx_phase_left == 0) begin
        rx_mode       <= $urandom_range(0, 2);
        rx_phase_left <= $urandom_range(10, 60);
      end else begin
        rx_phase_left <= rx_phase_left - 1;
      end
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= $urandom_range(0, 1);
        default: out_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Monitor: predict on every input beat, check on every result beat.
  always @(posedge clk) begin
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready)
      draw_results_q.push_back(next_draw(in_tuser, in_tdata[31:0], in_tdata[63:32],
                                         in_tdata[95:64]));
    if (rst_n && out_tvalid && out_tready) begin
      result_count <= result_count + 1;
      if (draw_results_q.size() == 0) begin
        $error("result beat with nothing expected: value %0d", $signed(out_tdata));
        fail_count++;
      end else begin
        want = draw_results_q.pop_front();
        if (out_tdata !== want.value) begin
          $error("value mismatch: expected %0d, got %0d", $signed(want.value),
                 $signed(out_tdata));
          fail_count++;
        end
        if (out_tuser[0] !== want.range_error) begin
          $error("range_error mismatch: expected %0b, got %0b", want.range_error,
                 out_tuser[0]);
          fail_count++;
        end
        if (out_tuser[1] !== want.bounds_swapped) begin
          $error("bounds_swapped mismatch: expected %0b, got %0b", want.bounds_swapped,
                 out_tuser[1]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: any beat on either side resets the count.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    in_tuser        = CMD_RESEED;
    out_tready      = 1'b0;
    in_fire         = 1'b0;
    burst_left      = 0;
    gap_left        = 0;
    result_count    = 0;
    long_stall_left = 0;
    long_stall_done = 1'b0;
    rx_mode         = 0;
    rx_phase_left   = 0;
    quiet_cycles    = 0;
    fail_count      = 0;
    gen_seed        = '0;

    // Directed: seed extremes, bound extremes, limit edges, reversed and equal bounds.
    add_request(CMD_DRAW,   32'h0000_0000, 32'sd0, 32'sd9);          // draw from reset seed
    add_request(CMD_RESEED, 32'h0000_0000, $urandom, $urandom);
    add_request(CMD_RESEED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    add_request(CMD_DRAW,   32'hFFFF_FFFF, 32'sd0, 32'(RANGE_LIMIT - 1)); // widest legal span
    add_request(CMD_DRAW,   32'h0000_0000, 32'sd0, 32'(RANGE_LIMIT));     // span at the limit
    add_request(CMD_DRAW,   $urandom, 32'(RANGE_LIMIT), 32'sd0);          // reversed and refused
    add_request(CMD_DRAW,   $urandom, 32'sd100, -32'sd100);               // reversed, accepted
    add_request(CMD_DRAW,   $urandom, 32'(INT_MIN), 32'(INT_MAX));        // widest span
    add_request(CMD_DRAW,   $urandom, 32'(INT_MAX), 32'(INT_MIN));
    add_request(CMD_DRAW,   $urandom, 32'(INT_MAX), 32'(INT_MAX));        // equal bounds
    add_request(CMD_DRAW,   $urandom, 32'(INT_MIN), 32'(INT_MIN));
    add_request(CMD_DRAW,   $urandom, 32'(INT_MAX - RANGE_LIMIT + 1), 32'(INT_MAX));
    add_request(CMD_DRAW,   $urandom, 32'(INT_MIN), 32'(INT_MIN + RANGE_LIMIT - 1));
    add_request(CMD_DRAW,   $urandom, 32'(INT_MIN + RANGE_LIMIT - 1), 32'(INT_MIN));
    add_request(CMD_DRAW,   $urandom, -32'sd1, -32'sd1);
    add_request(CMD_RESEED, 32'h1234_5678, 32'(INT_MAX), 32'(INT_MIN));
    add_request(CMD_DRAW,   $urandom, 32'sd0, 32'sd1);
    add_request(CMD_DRAW,   $urandom, -32'(RANGE_LIMIT), 32'sd0);         // limit, negative side
    add_request(CMD_RESEED, 32'h8000_0000, 32'(INT_MAX), 32'(INT_MAX));
    add_request(CMD_DRAW,   $urandom, -32'sd3, 32'sd3);
    add_request(CMD_DRAW,   $urandom, 32'sd5, 32'sd5);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Pause the sender until the directed results are all back.
    wait_drained();
    add_random(300);
    wait_drained();
    add_random(300);
    wait_drained();
    repeat (SETTLE) @(posedge clk);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
